FILE: rtl/core/rmv_pkg.sv
`timescale 1ns / 1ps
// Package for the running mean / variance block: widths, codes, payload and
// request types. No dependencies; used by every file in rtl/core.
package rmv_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int FRAC_BITS   = 16;
    localparam int COUNT_BITS  = 32;
    localparam int VAR_BITS    = 48;

    // signed difference of two samples
    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    // shift-add multiplier: A is taken whole, B one bit per cycle
    localparam int MUL_A_BITS    = VAR_BITS;
    localparam int MUL_B_BITS    = DIFF_BITS;
    localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
    localparam int MUL_STEP_BITS = $clog2(MUL_B_BITS + 1);
    // restoring divider: numerator/quotient share one shift register
    localparam int NUM_BITS      = PROD_BITS;
    localparam int DIV_STEP_BITS = $clog2(NUM_BITS + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic signed [31:0]      sample;
    } in_t;

    typedef struct packed {
        logic signed [31:0]      mean_out;
        logic [47:0]             variance_out;
        logic [31:0]             count_out;
        logic                    rejected;
    } out_t;

    typedef struct packed {
        logic                     start;
        logic [MUL_A_BITS-1:0]    a;
        logic [MUL_B_BITS-1:0]    b;
    } mul_req_t;

    typedef struct packed {
        logic                     start;
        logic [DIV_STEP_BITS-1:0] steps;
        logic [NUM_BITS-1:0]      numer;
        logic [COUNT_BITS-1:0]    denom;
    } div_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN1,
        ST_MEAN,
        ST_MULT,
        ST_DIVV,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/core/rmv_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on rmv_pkg.
module rmv_mul (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rmv_pkg::mul_req_t               req,
    output logic                            busy,
    output logic [rmv_pkg::PROD_BITS-1:0]   prod
);

    logic [rmv_pkg::MUL_A_BITS-1:0]    a_reg, a_next;
    logic [rmv_pkg::PROD_BITS-1:0]     p_reg, p_next;
    logic [rmv_pkg::MUL_STEP_BITS-1:0] cnt_reg, cnt_next;
    logic [rmv_pkg::MUL_A_BITS:0]      sum;

    always_comb begin
        a_next   = a_reg;
        p_next   = p_reg;
        cnt_next = cnt_reg;
        // upper half accumulates, the multiplier drains out the bottom
        sum = {1'b0, p_reg[rmv_pkg::PROD_BITS-1:rmv_pkg::MUL_B_BITS]}
            + (p_reg[0] ? {1'b0, a_reg} : '0);
        if (req.start) begin
            a_next   = req.a;
            p_next   = {{rmv_pkg::MUL_A_BITS{1'b0}}, req.b};
            cnt_next = rmv_pkg::MUL_STEP_BITS'(rmv_pkg::MUL_B_BITS);
        end else if (cnt_reg != '0) begin
            p_next   = {sum, p_reg[rmv_pkg::MUL_B_BITS-1:1]};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        a_reg <= a_next;
        p_reg <= p_next;
    end

    assign busy = (cnt_reg != '0);
    assign prod = p_reg;

endmodule

FILE: rtl/core/rmv_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle, step count per request.
// Depends on rmv_pkg.
module rmv_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rmv_pkg::div_req_t               req,
    output logic                            busy,
    output logic [rmv_pkg::NUM_BITS-1:0]    quot
);

    logic [rmv_pkg::NUM_BITS-1:0]      nq_reg, nq_next;
    logic [rmv_pkg::COUNT_BITS-1:0]    d_reg, d_next;
    logic [rmv_pkg::COUNT_BITS-1:0]    rem_reg, rem_next;
    logic [rmv_pkg::DIV_STEP_BITS-1:0] cnt_reg, cnt_next;
    logic [rmv_pkg::COUNT_BITS:0]      sh;
    logic [rmv_pkg::COUNT_BITS:0]      diff;
    logic                              ge;

    always_comb begin
        nq_next  = nq_reg;
        d_next   = d_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        sh   = {rem_reg, nq_reg[rmv_pkg::NUM_BITS-1]};
        diff = sh - {1'b0, d_reg};
        ge   = (sh >= {1'b0, d_reg});
        if (req.start) begin
            nq_next  = req.numer;
            d_next   = req.denom;
            rem_next = '0;
            cnt_next = req.steps;
        end else if (cnt_reg != '0) begin
            // remainder stays below the divisor, so it fits COUNT_BITS
            rem_next = ge ? diff[rmv_pkg::COUNT_BITS-1:0] : sh[rmv_pkg::COUNT_BITS-1:0];
            nq_next  = {nq_reg[rmv_pkg::NUM_BITS-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        nq_reg  <= nq_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = nq_reg;

endmodule

FILE: rtl/core/running_mean_variance.sv
`timescale 1ns / 1ps
// Welford running mean and population variance over signed Q16.16 samples,
// variance reported as unsigned Q32.16 (saturating), mean truncated toward
// zero. One request is worked on at a time. A clear, or a sample rejected
// because the count is saturated, goes straight from idle to the done state,
// which loads the result register and returns to idle for the next request.
// A sample reaches the done state only after the serial steps below. The
// 33-step mean division runs alongside the 33-step var*count multiply. A
// 33-step multiply then forms the cross term, and an 81-step restoring
// division by n+1 forms the new variance.
// The result register lets the next request be accepted while a result waits.
// A finished request that finds the result register still full waits for it
// to drain.
// Depends on rmv_pkg, rmv_mul and rmv_div.
module running_mean_variance (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rmv_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output rmv_pkg::out_t  m_data
);

    localparam int SB = rmv_pkg::SAMPLE_BITS;
    localparam int DB = rmv_pkg::DIFF_BITS;
    localparam int NB = rmv_pkg::NUM_BITS;
    localparam int VB = rmv_pkg::VAR_BITS;
    localparam int CB = rmv_pkg::COUNT_BITS;

    rmv_pkg::state_t        state_reg, state_next;
    logic [SB-1:0]          mean_reg, mean_next;
    logic [VB-1:0]          variance_reg, variance_next;
    logic [CB-1:0]          count_reg, count_next;
    logic [SB-1:0]          x_reg, x_next;
    logic [DB-1:0]          d1_mag_reg, d1_mag_next;
    logic                   d1_neg_reg, d1_neg_next;
    logic [SB-1:0]          nm_reg, nm_next;
    logic                   sub_reg, sub_next;
    logic [NB-1:0]          base_reg, base_next;
    logic                   rej_reg, rej_next;
    logic                   m_valid_reg, m_valid_next;
    rmv_pkg::out_t          m_data_reg, m_data_next;

    rmv_pkg::mul_req_t      mul_req;
    rmv_pkg::div_req_t      div_req;
    logic                   mul_busy;
    logic                   div_busy;
    logic [NB-1:0]          mul_prod;
    logic [NB-1:0]          div_quot;

    logic [DB-1:0]          d1_full, d1_mag;
    logic [DB-1:0]          qm, qs, nm_full;
    logic [DB-1:0]          d2_full, d2_mag;
    logic                   d2_neg;
    logic [NB-1:0]          term, num_sum, num;
    logic [NB:0]            num_dif;
    logic [VB-1:0]          var_sat;

    rmv_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .busy    (mul_busy),
        .prod    (mul_prod)
    );

    rmv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // datapath pieces between the serial units
    always_comb begin
        d1_full = {s_data.sample[SB-1], s_data.sample} - {mean_reg[SB-1], mean_reg};
        d1_mag  = d1_full[DB-1] ? (~d1_full + 1'b1) : d1_full;

        qm      = div_quot[DB-1:0];
        qs      = d1_neg_reg ? (~qm + 1'b1) : qm;
        nm_full = {mean_reg[SB-1], mean_reg} + qs;

        d2_full = {x_reg[SB-1], x_reg} - {nm_reg[SB-1], nm_reg};
        d2_neg  = d2_full[DB-1];
        d2_mag  = d2_neg ? (~d2_full + 1'b1) : d2_full;

        term    = mul_prod >> rmv_pkg::FRAC_BITS;
        num_sum = base_reg + term;
        num_dif = {1'b0, base_reg} - {1'b0, term};
        // opposite-sign cross term: clamp the numerator at zero
        if (sub_reg) begin
            num = num_dif[NB] ? '0 : num_dif[NB-1:0];
        end else begin
            num = num_sum;
        end

        var_sat = (|div_quot[NB-1:VB]) ? {VB{1'b1}} : div_quot[VB-1:0];
    end

    always_comb begin
        state_next    = state_reg;
        mean_next     = mean_reg;
        variance_next = variance_reg;
        count_next    = count_reg;
        x_next        = x_reg;
        d1_mag_next   = d1_mag_reg;
        d1_neg_next   = d1_neg_reg;
        nm_next       = nm_reg;
        sub_next      = sub_reg;
        base_next     = base_reg;
        rej_next      = rej_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mul_req       = '0;
        div_req       = '0;
        s_ready       = 1'b0;

        unique case (state_reg)
            rmv_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    rej_next = 1'b0;
                    if (s_data.operation == rmv_pkg::OP_CLEAR) begin
                        mean_next     = '0;
                        variance_next = '0;
                        count_next    = '0;
                        state_next    = rmv_pkg::ST_DONE;
                    end else if (count_reg == rmv_pkg::COUNT_MAX) begin
                        rej_next   = 1'b1;
                        state_next = rmv_pkg::ST_DONE;
                    end else begin
                        x_next        = s_data.sample;
                        d1_mag_next   = d1_mag;
                        d1_neg_next   = d1_full[DB-1];
                        div_req.start = 1'b1;
                        div_req.steps = rmv_pkg::DIV_STEP_BITS'(DB);
                        div_req.numer = {d1_mag, {(NB-DB){1'b0}}};
                        div_req.denom = count_reg + 1'b1;
                        mul_req.start = 1'b1;
                        mul_req.a     = variance_reg;
                        mul_req.b     = rmv_pkg::MUL_B_BITS'(count_reg);
                        state_next    = rmv_pkg::ST_RUN1;
                    end
                end
            end
            rmv_pkg::ST_RUN1: begin
                if (!div_busy && !mul_busy) begin
                    nm_next    = nm_full[SB-1:0];
                    base_next  = mul_prod;
                    state_next = rmv_pkg::ST_MEAN;
                end
            end
            rmv_pkg::ST_MEAN: begin
                sub_next      = (d1_neg_reg != d2_neg) && (d1_mag_reg != '0) && (d2_mag != '0);
                mul_req.start = 1'b1;
                mul_req.a     = rmv_pkg::MUL_A_BITS'(d1_mag_reg);
                mul_req.b     = d2_mag;
                state_next    = rmv_pkg::ST_MULT;
            end
            rmv_pkg::ST_MULT: begin
                if (!mul_busy) begin
                    div_req.start = 1'b1;
                    div_req.steps = rmv_pkg::DIV_STEP_BITS'(NB);
                    div_req.numer = num;
                    div_req.denom = count_reg + 1'b1;
                    state_next    = rmv_pkg::ST_DIVV;
                end
            end
            rmv_pkg::ST_DIVV: begin
                if (!div_busy) begin
                    variance_next = var_sat;
                    mean_next     = nm_reg;
                    count_next    = count_reg + 1'b1;
                    state_next    = rmv_pkg::ST_DONE;
                end
            end
            rmv_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.mean_out      = mean_reg;
                    m_data_next.variance_out  = variance_reg;
                    m_data_next.count_out     = count_reg;
                    m_data_next.rejected      = rej_reg;
                    state_next                = rmv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rmv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rmv_pkg::ST_IDLE;
            mean_reg     <= '0;
            variance_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mean_reg     <= mean_next;
            variance_reg <= variance_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
        x_reg      <= x_next;
        d1_mag_reg <= d1_mag_next;
        d1_neg_reg <= d1_neg_next;
        nm_reg     <= nm_next;
        sub_reg    <= sub_next;
        base_reg   <= base_next;
        rej_reg    <= rej_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rmv_pkg::ST_IDLE) |-> (!div_busy && !mul_busy))
        else $error("arithmetic unit busy while idle");

    a_empty_stats: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (variance_reg == '0 && mean_reg == '0))
        else $error("statistics nonzero with zero count");

    a_reject_at_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.rejected) |-> (m_data_reg.count_out == rmv_pkg::COUNT_MAX))
        else $error("rejection reported below saturated count");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rmv_pkg::ST_DIVV && !div_busy)
            |=> (count_reg == CB'($past(count_reg) + 1'b1)))
        else $error("sample did not advance count by one");
`endif

endmodule
